// File: hw/rtl/line_follow_speed_control_core_assert.svh
// Assertion macros for the line follower speed control core.
`ifndef LINE_FOLLOW_SPEED_CONTROL_CORE_ASSERT_SVH
`define LINE_FOLLOW_SPEED_CONTROL_CORE_ASSERT_SVH

`ifndef SYNTH
`define LFSC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");
`define LFSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next cycle");
`else
`define LFSC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LFSC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hw/rtl/lfsc_pkg.sv
// Shared constants, types and helpers of the line follower speed control core.
package lfsc_pkg;

   localparam int SENSOR_COUNT    = 5;
   localparam int SAMPLE_BITS_DEF = 10;
   localparam int THR_W           = 10;
   localparam int SPEED_W         = 8;
   localparam int GAIN_W          = 12;
   localparam int CSR_DATA_W      = 12;
   localparam int CSR_IDX_W       = 2;
   localparam int CNT_W           = $clog2(SENSOR_COUNT + 1);
   localparam int WSUM_W          = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_BLACK_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SPEED      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_GAIN       = 2'd2;

   localparam logic [THR_W-1:0]   THRESHOLD_RST = 10'd422;
   localparam logic [SPEED_W-1:0] BASE_RST      = 8'd100;
   localparam logic [GAIN_W-1:0]  GAIN_RST      = 12'd461;

   typedef struct packed {
      logic [THR_W-1:0]   threshold;
      logic [SPEED_W-1:0] base;
      logic [GAIN_W-1:0]  gain;
   } lfsc_cfg_type;

   typedef struct packed {
      logic                     valid;
      logic [CNT_W-1:0]         count;
      logic signed [WSUM_W-1:0] wsum;
   } lfsc_pos_type;

   function automatic logic signed [WSUM_W-1:0] lane_weight(input int idx);
      lane_weight = WSUM_W'(SENSOR_COUNT / 2 - idx);
   endfunction

endpackage

// File: hw/rtl/line_follow_speed_control_core.sv
// Top level of the line follower speed control core: lanes, merge and steering.
//
// Request channel: start with five reflectance samples; a request is taken at a
// rising edge where start is high and busy is low. busy is high only in the
// cycle after reset, so a request can be taken on every cycle.
// Result channel: rsp_strobe marks left/right speed and line_lost for exactly
// one cycle, after the merge, product, divide and output registers of the request.
// Results come out in request order, one per request.
// Throughput: one request per cycle; five compare lanes, one merge register,
// then a multiply stage, a reciprocal divide stage and a clamp stage.
// The receiver cannot stall; results are never held.
// Configuration: csr_write_en with csr_index and csr_write_data writes a
// register at the edge, no wait. Index 0 threshold, 1 base speed, 2 gain
// (Q4.8); other indexes are ignored. Write only while no request is in flight.
// Reset: synchronous, active high; clears the pipeline and restores threshold
// 422, base speed 100 and gain 461.
module line_follow_speed_control_core #(
   parameter int SAMPLE_BITS = lfsc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [SAMPLE_BITS-1:0]            req_sample_far_left,
   input  logic [SAMPLE_BITS-1:0]            req_sample_left,
   input  logic [SAMPLE_BITS-1:0]            req_sample_center,
   input  logic [SAMPLE_BITS-1:0]            req_sample_right,
   input  logic [SAMPLE_BITS-1:0]            req_sample_far_right,
   input  logic                              csr_write_en,
   input  logic [lfsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lfsc_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output logic                              rsp_strobe,
   output logic [lfsc_pkg::SPEED_W-1:0]      rsp_left_speed,
   output logic [lfsc_pkg::SPEED_W-1:0]      rsp_right_speed,
   output logic                              rsp_line_lost
);
   import lfsc_pkg::*;

   logic                     busy_ff;
   logic [THR_W-1:0]         threshold_ff;
   logic [SPEED_W-1:0]       base_ff;
   logic [GAIN_W-1:0]        gain_ff;
   logic                     accept;
   logic [SAMPLE_BITS-1:0]   sample_arr [SENSOR_COUNT];
   logic [SENSOR_COUNT-1:0]  hits;
   lfsc_cfg_type             cfg;
   lfsc_pos_type             pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RST;
         base_ff      <= BASE_RST;
         gain_ff      <= GAIN_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_BLACK_THRESHOLD: threshold_ff <= csr_write_data[THR_W-1:0];
            CSR_BASE_SPEED:      base_ff      <= csr_write_data[SPEED_W-1:0];
            CSR_TURN_GAIN:       gain_ff      <= csr_write_data[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   assign cfg.threshold = threshold_ff;
   assign cfg.base      = base_ff;
   assign cfg.gain      = gain_ff;

   assign sample_arr[0] = req_sample_far_left;
   assign sample_arr[1] = req_sample_left;
   assign sample_arr[2] = req_sample_center;
   assign sample_arr[3] = req_sample_right;
   assign sample_arr[4] = req_sample_far_right;

   for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
      lfsc_lane #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_lane (
         .sample    (sample_arr[g]),
         .threshold (threshold_ff),
         .hit       (hits[g])
      );
   end

   lfsc_merge u_merge (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .hits   (hits),
      .pos    (pos)
   );

   lfsc_steer u_steer (
      .clock           (clock),
      .reset           (reset),
      .pos             (pos),
      .cfg             (cfg),
      .rsp_strobe      (rsp_strobe),
      .rsp_left_speed  (rsp_left_speed),
      .rsp_right_speed (rsp_right_speed),
      .rsp_line_lost   (rsp_line_lost)
   );

endmodule

// File: hw/rtl/lfsc_lane.sv
// One sensor lane: compare a reflectance sample against the black threshold.
module lfsc_lane #(
   parameter int SAMPLE_BITS = lfsc_pkg::SAMPLE_BITS_DEF
) (
   input  logic [SAMPLE_BITS-1:0]    sample,
   input  logic [lfsc_pkg::THR_W-1:0] threshold,
   output logic                      hit
);
   import lfsc_pkg::*;

   localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

   assign hit = CMP_W'(sample) < CMP_W'(threshold);

endmodule

// File: hw/rtl/lfsc_merge.sv
// Merge stage: count the lanes on the line and sum their weights.
module lfsc_merge (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [lfsc_pkg::SENSOR_COUNT-1:0] hits,
   output lfsc_pkg::lfsc_pos_type           pos
);
   import lfsc_pkg::*;

   logic                     valid_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic signed [WSUM_W-1:0] wsum_ff;
   logic signed [WSUM_W-1:0] wsum_in;

   always_comb begin
      count_in = '0;
      wsum_in  = '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (hits[i]) begin
            count_in = count_in + CNT_W'(1);
            wsum_in  = wsum_in + lane_weight(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      wsum_ff  <= wsum_in;
   end

   assign pos.valid = valid_ff;
   assign pos.count = count_ff;
   assign pos.wsum  = wsum_ff;

endmodule

// File: hw/rtl/lfsc_steer.sv
// Steering pipeline: scale the position error, divide by the count, clamp speeds.
`include "line_follow_speed_control_core_assert.svh"

module lfsc_steer (
   input  logic                             clock,
   input  logic                             reset,
   input  lfsc_pkg::lfsc_pos_type           pos,
   input  lfsc_pkg::lfsc_cfg_type           cfg,
   output logic                             rsp_strobe,
   output logic [lfsc_pkg::SPEED_W-1:0]     rsp_left_speed,
   output logic [lfsc_pkg::SPEED_W-1:0]     rsp_right_speed,
   output logic                             rsp_line_lost
);
   import lfsc_pkg::*;

   localparam int GM_W  = SPEED_W + GAIN_W;
   localparam int P_W   = GM_W + WSUM_W + 1;
   localparam int MAG_W = P_W - 1;
   localparam int QX_W  = MAG_W - 8;
   localparam int QC_W  = QX_W + 3;
   localparam int SUM_W = QX_W + 2;
   localparam int RP_W  = 2 * QX_W;
   localparam logic [QX_W-1:0]    RECIP_3  = QX_W'(16'hAAAB);
   localparam logic [QX_W-1:0]    RECIP_5  = QX_W'(16'hCCCD);
   localparam int                 SHIFT_3  = 17;
   localparam int                 SHIFT_5  = 18;
   localparam logic [SPEED_W-1:0] THIRD_MUL = 8'd171;
   localparam int                 THIRD_SH  = 9;
   localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

   function automatic logic [SPEED_W-1:0] clamp_speed(input logic signed [SUM_W-1:0] v);
      if (v < 0) begin
         clamp_speed = '0;
      end else if (v > SUM_W'(SPEED_MAX)) begin
         clamp_speed = SPEED_MAX;
      end else begin
         clamp_speed = v[SPEED_W-1:0];
      end
   endfunction

   // base times gain, registered; steady while base and gain are not written
   logic [GM_W-1:0] gm_ff;

   // product stage
   logic                    v2_ff;
   logic [CNT_W-1:0]        cnt2_ff;
   logic signed [P_W-1:0]   p2_ff;
   logic signed [P_W-1:0]   p2_in;

   // divide stage
   logic                    v3_ff;
   logic [CNT_W-1:0]        cnt3_ff;
   logic                    neg3_ff;
   logic                    lownz3_ff;
   logic [QX_W-1:0]         xq3_ff;
   logic [QX_W-1:0]         q3_ff;
   logic [QX_W-1:0]         q3_in;
   logic                    neg3_in;
   logic [MAG_W-1:0]        mag;
   logic [QX_W-1:0]         xq;
   logic [RP_W-1:0]         prod3;
   logic [RP_W-1:0]         prod5;

   // output stage
   logic                    strobe_ff;
   logic [SPEED_W-1:0]      left_ff;
   logic [SPEED_W-1:0]      right_ff;
   logic                    lost_ff;
   logic [SPEED_W-1:0]      left_in;
   logic [SPEED_W-1:0]      right_in;
   logic [QC_W-1:0]         qc;
   logic                    exact;
   logic signed [SUM_W-1:0] base_s;
   logic signed [SUM_W-1:0] q_s;
   logic signed [SUM_W-1:0] qup_s;
   logic [2*SPEED_W-1:0]    third_prod;

   assign p2_in = P_W'(pos.wsum) * P_W'($signed({1'b0, gm_ff}));

   always_comb begin
      neg3_in = p2_ff[P_W-1];
      mag     = neg3_in ? MAG_W'(-p2_ff) : MAG_W'(p2_ff);
      xq      = mag[MAG_W-1:8];
      prod3   = RP_W'(xq) * RP_W'(RECIP_3);
      prod5   = RP_W'(xq) * RP_W'(RECIP_5);
      case (cnt2_ff)
         CNT_W'(1): q3_in = xq;
         CNT_W'(2): q3_in = xq >> 1;
         CNT_W'(3): q3_in = QX_W'(prod3 >> SHIFT_3);
         CNT_W'(4): q3_in = xq >> 2;
         CNT_W'(5): q3_in = QX_W'(prod5 >> SHIFT_5);
         default:   q3_in = '0;
      endcase
   end

   always_comb begin
      case (cnt3_ff)
         CNT_W'(1): qc = QC_W'(q3_ff);
         CNT_W'(2): qc = QC_W'(q3_ff) << 1;
         CNT_W'(3): qc = QC_W'(q3_ff) + (QC_W'(q3_ff) << 1);
         CNT_W'(4): qc = QC_W'(q3_ff) << 2;
         CNT_W'(5): qc = QC_W'(q3_ff) + (QC_W'(q3_ff) << 2);
         default:   qc = '0;
      endcase
      exact      = !lownz3_ff && (qc == QC_W'(xq3_ff));
      base_s     = SUM_W'($signed({1'b0, cfg.base}));
      q_s        = SUM_W'($signed({1'b0, q3_ff}));
      qup_s      = q_s + (exact ? SUM_W'(0) : SUM_W'(1));
      third_prod = (2*SPEED_W)'(cfg.base) * (2*SPEED_W)'(THIRD_MUL);
      if (cnt3_ff == '0) begin
         left_in  = SPEED_W'(third_prod >> THIRD_SH);
         right_in = cfg.base[SPEED_W-1] ? SPEED_MAX : {cfg.base[SPEED_W-2:0], 1'b0};
      end else if (neg3_ff) begin
         left_in  = clamp_speed(base_s + q_s);
         right_in = clamp_speed(base_s - qup_s);
      end else begin
         left_in  = clamp_speed(base_s - qup_s);
         right_in = clamp_speed(base_s + q_s);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         v2_ff     <= pos.valid;
         v3_ff     <= v2_ff;
         strobe_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      gm_ff     <= GM_W'(cfg.base) * GM_W'(cfg.gain);
      cnt2_ff   <= pos.count;
      p2_ff     <= p2_in;
      cnt3_ff   <= cnt2_ff;
      neg3_ff   <= neg3_in;
      lownz3_ff <= |mag[7:0];
      xq3_ff    <= xq;
      q3_ff     <= q3_in;
      left_ff   <= left_in;
      right_ff  <= right_in;
      lost_ff   <= (cnt3_ff == '0);
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_left_speed  = left_ff;
   assign rsp_right_speed = right_ff;
   assign rsp_line_lost   = lost_ff;

   `LFSC_ASSERT_IMPLY(a_latency, clock, reset, strobe_ff, $past(pos.valid, 3))
   `LFSC_ASSERT_IMPLY(a_lost_count, clock, reset, strobe_ff && lost_ff, $past(pos.count, 3) == '0)
   `LFSC_ASSERT_IMPLY(a_lost_order, clock, reset, strobe_ff && lost_ff, right_ff >= left_ff)
   `LFSC_ASSERT_IMPLY(a_centered, clock, reset, strobe_ff && !lost_ff && ($past(pos.wsum, 3) == '0), left_ff == right_ff)

endmodule
